// ===== rtl/frame_escape_checksum_encoder_unit_defines.svh =====
// assertion macros shared by the framer modules
`ifndef FRAME_ESCAPE_CHECKSUM_ENCODER_UNIT_DEFINES_SVH
`define FRAME_ESCAPE_CHECKSUM_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FECS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FECS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fecs_pkg.sv =====
// shared types and constants of the byte-stuffing framer
package fecs_pkg;

    localparam int BYTE_W     = 8;
    localparam int SUM_W      = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam logic [OP_W-1:0] OP_START = 2'd0;
    localparam logic [OP_W-1:0] OP_DATA  = 2'd1;
    localparam logic [OP_W-1:0] OP_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_FLAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE     = 2'd2;

    localparam logic [BYTE_W-1:0] BEGIN_FLAG_RST = 8'd192;
    localparam logic [BYTE_W-1:0] END_FLAG_RST   = 8'd193;
    localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'd125;
    localparam logic [BYTE_W-1:0] ESC_XOR        = 8'h20;

    // token slots within one queued job
    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_DATA,
        KIND_END
    } kind_t;

    // one classified request: start carries address/control, end carries sum hi/lo
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] b0;
        logic [BYTE_W-1:0] b1;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

endpackage

// ===== rtl/fecs_front.sv =====
// front end: accepts requests, tracks frame state and checksum, queues jobs
module fecs_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fecs_pkg::OP_W-1:0]      op,
    input  logic [fecs_pkg::BYTE_W-1:0]    address,
    input  logic [fecs_pkg::BYTE_W-1:0]    control_byte,
    input  logic [fecs_pkg::BYTE_W-1:0]    payload_byte,
    input  logic                           q_full,
    output fecs_pkg::push_t                push
);

    logic                         in_frame_reg;
    logic                         in_frame_next;
    logic [fecs_pkg::SUM_W-1:0]   sum_reg;
    logic [fecs_pkg::SUM_W-1:0]   sum_next;
    logic                         accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        in_frame_next  = in_frame_reg;
        sum_next       = sum_reg;
        push.valid     = 1'b0;
        push.job.kind  = fecs_pkg::KIND_DATA;
        push.job.b0    = payload_byte;
        push.job.b1    = control_byte;
        if (accept)
        begin
            unique case (op)
                fecs_pkg::OP_START:
                begin
                    // a start inside a frame abandons the open one
                    push.valid    = 1'b1;
                    push.job.kind = fecs_pkg::KIND_START;
                    push.job.b0   = address;
                    push.job.b1   = control_byte;
                    sum_next      = {8'b0, address} + {8'b0, control_byte};
                    in_frame_next = 1'b1;
                end
                fecs_pkg::OP_DATA:
                begin
                    if (in_frame_reg)
                    begin
                        push.valid    = 1'b1;
                        push.job.kind = fecs_pkg::KIND_DATA;
                        push.job.b0   = payload_byte;
                        sum_next      = sum_reg + {8'b0, payload_byte};
                    end
                end
                fecs_pkg::OP_END:
                begin
                    if (in_frame_reg)
                    begin
                        push.valid    = 1'b1;
                        push.job.kind = fecs_pkg::KIND_END;
                        push.job.b0   = sum_reg[15:8];
                        push.job.b1   = sum_reg[7:0];
                        sum_next      = '0;
                        in_frame_next = 1'b0;
                    end
                end
                default:
                begin
                    in_frame_next = in_frame_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            sum_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
        end
    end

endmodule

// ===== rtl/fecs_fifo.sv =====
// short job queue between the front and back ends
`include "frame_escape_checksum_encoder_unit_defines.svh"
module fecs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  fecs_pkg::push_t     push,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output fecs_pkg::job_t      head
);

    fecs_pkg::job_t                    mem_reg [fecs_pkg::FIFO_DEPTH];
    logic [fecs_pkg::FIFO_AW-1:0]      wr_ptr_reg;
    logic [fecs_pkg::FIFO_AW-1:0]      rd_ptr_reg;
    logic [fecs_pkg::FIFO_CW-1:0]      count_reg;
    logic [fecs_pkg::FIFO_CW-1:0]      count_next;
    logic                              do_push;
    logic                              do_pop;

    assign full       = (count_reg == fecs_pkg::FIFO_CW'(fecs_pkg::FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `FECS_ASSERT_NOW(a_no_push_when_full, full, !push.valid, "job pushed into full queue")
    `FECS_ASSERT_NOW(a_no_pop_when_empty, pop, head_valid, "pop from empty queue")
    `FECS_ASSERT_NOW(a_count_in_range, 1'b1, count_reg <= fecs_pkg::FIFO_CW'(fecs_pkg::FIFO_DEPTH), "queue count overflow")

endmodule

// ===== rtl/fecs_back.sv =====
// back end: expands queued jobs into stuffed line bytes, one per cycle unless the output stalls
`include "frame_escape_checksum_encoder_unit_defines.svh"
module fecs_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fecs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fecs_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                head_valid,
    input  fecs_pkg::job_t                      head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fecs_pkg::BYTE_W-1:0]         line_byte,
    output logic                                run_last,
    output logic                                frame_done
);

    logic [fecs_pkg::BYTE_W-1:0] begin_flag_reg;
    logic [fecs_pkg::BYTE_W-1:0] end_flag_reg;
    logic [fecs_pkg::BYTE_W-1:0] escape_reg;

    logic [1:0]                  slot_reg;
    logic [1:0]                  slot_next;
    logic                        esc_pend_reg;
    logic                        esc_pend_next;

    logic                        out_valid_reg;
    logic [fecs_pkg::BYTE_W-1:0] line_byte_reg;
    logic                        run_last_reg;
    logic                        frame_done_reg;

    logic [fecs_pkg::BYTE_W-1:0] tok_byte;
    logic                        tok_raw;
    logic                        tok_last;
    logic                        tok_done;
    logic                        needs_esc;
    logic                        advance;
    logic                        tok_finish;
    logic [fecs_pkg::BYTE_W-1:0] emit_byte;

    // current token of the head job
    always_comb
    begin
        tok_byte = head.b0;
        tok_raw  = 1'b0;
        tok_last = 1'b0;
        tok_done = 1'b0;
        unique case (head.kind)
            fecs_pkg::KIND_START:
            begin
                unique case (slot_reg)
                    fecs_pkg::SLOT_FIRST:
                    begin
                        tok_byte = begin_flag_reg;
                        tok_raw  = 1'b1;
                    end
                    fecs_pkg::SLOT_SECOND:
                    begin
                        tok_byte = head.b0;
                    end
                    default:
                    begin
                        tok_byte = head.b1;
                        tok_last = 1'b1;
                    end
                endcase
            end
            fecs_pkg::KIND_END:
            begin
                unique case (slot_reg)
                    fecs_pkg::SLOT_FIRST:
                    begin
                        tok_byte = head.b0;
                    end
                    fecs_pkg::SLOT_SECOND:
                    begin
                        tok_byte = head.b1;
                    end
                    default:
                    begin
                        tok_byte = end_flag_reg;
                        tok_raw  = 1'b1;
                        tok_last = 1'b1;
                        tok_done = 1'b1;
                    end
                endcase
            end
            default:
            begin
                tok_byte = head.b0;
                tok_last = 1'b1;
            end
        endcase
    end

    assign needs_esc = !tok_raw && ((tok_byte == begin_flag_reg) ||
                                    (tok_byte == end_flag_reg) ||
                                    (tok_byte == escape_reg));
    assign advance   = head_valid && (!out_valid_reg || out_ready);
    // a stuffed token emits the escape byte first, then the token XORed with ESC_XOR
    assign tok_finish = esc_pend_reg || !needs_esc;
    assign emit_byte  = esc_pend_reg ? (tok_byte ^ fecs_pkg::ESC_XOR) :
                        (needs_esc ? escape_reg : tok_byte);
    assign pop        = advance && tok_finish && tok_last;

    always_comb
    begin
        slot_next     = slot_reg;
        esc_pend_next = esc_pend_reg;
        if (advance)
        begin
            if (!tok_finish)
            begin
                esc_pend_next = 1'b1;
            end
            else
            begin
                esc_pend_next = 1'b0;
                slot_next     = tok_last ? fecs_pkg::SLOT_FIRST : slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_flag_reg <= fecs_pkg::BEGIN_FLAG_RST;
            end_flag_reg   <= fecs_pkg::END_FLAG_RST;
            escape_reg     <= fecs_pkg::ESCAPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fecs_pkg::CFG_BEGIN_FLAG: begin_flag_reg <= cfg_data;
                fecs_pkg::CFG_END_FLAG:   end_flag_reg   <= cfg_data;
                fecs_pkg::CFG_ESCAPE:     escape_reg     <= cfg_data;
                default:                  escape_reg     <= escape_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= fecs_pkg::SLOT_FIRST;
            esc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg     <= slot_next;
            esc_pend_reg <= esc_pend_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            line_byte_reg  <= emit_byte;
            run_last_reg   <= tok_finish && tok_last;
            frame_done_reg <= tok_done && tok_finish;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_byte  = line_byte_reg;
    assign run_last   = run_last_reg;
    assign frame_done = frame_done_reg;

    `FECS_ASSERT_NOW(a_done_is_last, out_valid_reg && frame_done_reg, run_last_reg, "end flag not marked last")
    `FECS_ASSERT_NOW(a_slot_legal, 1'b1, slot_reg != 2'd3, "token slot out of range")
    `FECS_ASSERT_NOW(a_esc_pend_has_job, esc_pend_reg, head_valid, "escape pending without a job")
    `FECS_ASSERT_NEXT(a_out_held, out_valid_reg && !out_ready, out_valid_reg && $stable(line_byte_reg), "stalled line byte changed")

endmodule

// ===== rtl/frame_escape_checksum_encoder_unit.sv =====
// top level of the byte-stuffing transmit framer
//
//  channel   | handshake             | payload
//  ----------+-----------------------+------------------------------------------
//  request   | in_valid / in_ready   | op, address, control_byte, payload_byte
//  line out  | out_valid / out_ready | line_byte, run_last, frame_done
//  config    | cfg_we                | cfg_index, cfg_data
//
// the back end emits one line byte per cycle unless the output stalls, via the
// single output register; a request yields 1-2 line bytes for payload, 3-5 for
// start and 3-5 for end; the front end takes one request per cycle while the
// four-entry job queue has room. reset restores the default flags and closes
// any open frame; an output stall holds the line byte and fills the queue.
module frame_escape_checksum_encoder_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fecs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fecs_pkg::BYTE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [fecs_pkg::OP_W-1:0]           op,
    input  logic [fecs_pkg::BYTE_W-1:0]         address,
    input  logic [fecs_pkg::BYTE_W-1:0]         control_byte,
    input  logic [fecs_pkg::BYTE_W-1:0]         payload_byte,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [fecs_pkg::BYTE_W-1:0]         line_byte,
    output logic                                run_last,
    output logic                                frame_done
);

    fecs_pkg::push_t push;
    fecs_pkg::job_t  head;
    logic            q_full;
    logic            head_valid;
    logic            pop;

    fecs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .address      (address),
        .control_byte (control_byte),
        .payload_byte (payload_byte),
        .q_full       (q_full),
        .push         (push)
    );

    fecs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    fecs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_byte  (line_byte),
        .run_last   (run_last),
        .frame_done (frame_done)
    );

endmodule
